>>> hdl/one_shot_timer_slot_pool_macros.svh
// Assertion macros used by the timer slot pool engine.
`ifndef ONE_SHOT_TIMER_SLOT_POOL_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_POOL_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define OTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication built on the macro above.
`define OTSP_ASSERT_IMPLY(lbl, pre, post, msg) \
  `OTSP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

>>> hdl/otsp_pkg.sv
// Types, constants and helpers shared by the timer slot pool modules.
`timescale 1ns / 1ps

package otsp_pkg;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int unsigned RES_MAX     = 8;
  localparam int unsigned FIRE_W      = $clog2(RES_MAX);
  localparam int unsigned FIRE_CNT_W  = $clog2(RES_MAX + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PEND_MAX    = 15;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_TICK   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_READY = 3'd1,
    STATUS_BAD_PARAM = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_ARM,
    OP_CANCEL,
    OP_TICK,
    OP_REPLY
  } cmd_op_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_FLUSH,
    ENG_FIRE_RD,
    ENG_FIRE_WR,
    ENG_RESP
  } eng_state_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] callback_id;
    logic [31:0] context_word;
    logic [31:0] wait_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        fired;
    logic [31:0] fired_callback;
    logic [31:0] fired_context;
    logic        last;
    logic [3:0]  pending_count;
  } out_item_t;

  // Classified command; time_ms is the deadline for an arm and the current
  // time for a tick.
  typedef struct packed {
    cmd_op_e     op;
    status_e     status;
    logic [31:0] callback;
    logic [31:0] context_word;
    logic [31:0] time_ms;
  } cmd_t;

  function automatic logic [3:0] sat_pend(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+3:0] wide;
    wide = {4'b0000, cnt};
    if (wide > (CNT_W + 4)'(PEND_MAX)) begin
      return 4'd15;
    end
    return wide[3:0];
  endfunction

endpackage

>>> hdl/otsp_front.sv
// Front end: accepts input transactions and classifies them into commands.
`timescale 1ns / 1ps

module otsp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  otsp_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output otsp_pkg::cmd_t     q_data_o
);

  // The front tracks readiness in arrival order, so it never depends on
  // how far the back end has progressed.
  logic ready_q, ready_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.op           = otsp_pkg::OP_REPLY;
    q_data_o.status       = otsp_pkg::STATUS_OK;
    q_data_o.callback     = in_data_i.callback_id;
    q_data_o.context_word = in_data_i.context_word;
    q_data_o.time_ms      = in_data_i.now_ms;
    unique case (in_data_i.action)
      otsp_pkg::ACT_INIT: begin
        q_data_o.op = otsp_pkg::OP_INIT;
      end
      otsp_pkg::ACT_ARM: begin
        q_data_o.time_ms = in_data_i.now_ms + in_data_i.wait_ms;
        if (!ready_q) begin
          q_data_o.status = otsp_pkg::STATUS_NOT_READY;
        end else if (in_data_i.callback_id == 32'd0) begin
          q_data_o.status = otsp_pkg::STATUS_BAD_PARAM;
        end else begin
          q_data_o.op = otsp_pkg::OP_ARM;
        end
      end
      otsp_pkg::ACT_CANCEL: begin
        if (in_data_i.callback_id == 32'd0) begin
          q_data_o.status = otsp_pkg::STATUS_BAD_PARAM;
        end else begin
          q_data_o.op = otsp_pkg::OP_CANCEL;
        end
      end
      otsp_pkg::ACT_TICK: begin
        if (!ready_q) begin
          q_data_o.status = otsp_pkg::STATUS_NOT_READY;
        end else begin
          q_data_o.op = otsp_pkg::OP_TICK;
        end
      end
      default: begin
        q_data_o.op = otsp_pkg::OP_REPLY;
      end
    endcase
  end

  assign ready_d = ready_q || (q_push_o && (in_data_i.action == otsp_pkg::ACT_INIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= ready_d;
    end
  end

endmodule

>>> hdl/otsp_cmd_queue.sv
// Short command queue between the front end and the slot engine.
`timescale 1ns / 1ps

module otsp_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  otsp_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output otsp_pkg::cmd_t pop_data_o,
  output logic           empty_o
);

  otsp_pkg::cmd_t entry_q [otsp_pkg::QUEUE_DEPTH];
  logic [otsp_pkg::QUEUE_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [otsp_pkg::QUEUE_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [otsp_pkg::QCNT_W-1:0]  count_q, count_d;

  localparam logic [otsp_pkg::QUEUE_W-1:0] PtrLast =
    otsp_pkg::QUEUE_W'(otsp_pkg::QUEUE_DEPTH - 1);

  assign full_o     = (count_q == otsp_pkg::QCNT_W'(otsp_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/otsp_engine.sv
// Back end: scans the slot store, applies commands and emits results.
`timescale 1ns / 1ps
`include "one_shot_timer_slot_pool_macros.svh"

module otsp_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  otsp_pkg::cmd_t      q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otsp_pkg::out_item_t out_data_o
);

  localparam int unsigned SlotW  = otsp_pkg::SLOT_W;
  localparam int unsigned CntW   = otsp_pkg::CNT_W;
  localparam int unsigned FireW  = otsp_pkg::FIRE_W;
  localparam int unsigned FireCW = otsp_pkg::FIRE_CNT_W;
  localparam logic [SlotW-1:0] IdxLast = SlotW'(otsp_pkg::SLOT_COUNT - 1);

  otsp_pkg::eng_state_e state_q, state_d;
  otsp_pkg::cmd_t       cmd_q, cmd_d;
  otsp_pkg::status_e    status_q, status_d;

  logic [SlotW-1:0]  idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [SlotW-1:0]  chk_idx_q, chk_idx_d;
  logic              match_q, match_d;
  logic [SlotW-1:0]  match_idx_q, match_idx_d;
  logic              free_q, free_d;
  logic [SlotW-1:0]  free_idx_q, free_idx_d;
  logic [FireCW-1:0] fire_n_q, fire_n_d;
  logic [SlotW-1:0]  fire_list_q [otsp_pkg::RES_MAX];
  logic [SlotW-1:0]  fire_list_d [otsp_pkg::RES_MAX];
  logic [FireW-1:0]  fire_k_q, fire_k_d;
  logic [CntW-1:0]   pend_out_q, pend_out_d;
  logic [otsp_pkg::SLOT_COUNT-1:0] valid_q, valid_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  otsp_pkg::out_item_t out_q, out_d;

  // Slot store: one write port, one registered read port.
  logic [31:0] cb_mem  [otsp_pkg::SLOT_COUNT];
  logic [31:0] ctx_mem [otsp_pkg::SLOT_COUNT];
  logic [31:0] dl_mem  [otsp_pkg::SLOT_COUNT];
  logic [31:0] rd_cb_q, rd_ctx_q, rd_dl_q;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic        out_free;
  logic        hit_valid;
  logic        key_eq;
  logic [31:0] age;
  logic        fire_last;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign hit_valid = valid_q[chk_idx_q];
  assign key_eq    = (rd_cb_q == cmd_q.callback) && (rd_ctx_q == cmd_q.context_word);
  assign age       = cmd_q.time_ms - rd_dl_q;
  assign fire_last = ((FireCW'(fire_k_q) + FireCW'(1)) == fire_n_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otsp_pkg::ENG_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.op == otsp_pkg::OP_INIT || q_data_i.op == otsp_pkg::OP_REPLY) begin
            state_d = otsp_pkg::ENG_RESP;
          end else begin
            state_d = otsp_pkg::ENG_SCAN;
          end
        end
      end
      otsp_pkg::ENG_SCAN: begin
        if (idx_q == IdxLast) begin
          state_d = otsp_pkg::ENG_FLUSH;
        end
      end
      otsp_pkg::ENG_FLUSH: begin
        if (cmd_q.op == otsp_pkg::OP_TICK && fire_n_d != '0) begin
          state_d = otsp_pkg::ENG_FIRE_RD;
        end else begin
          state_d = otsp_pkg::ENG_RESP;
        end
      end
      otsp_pkg::ENG_FIRE_RD: begin
        state_d = otsp_pkg::ENG_FIRE_WR;
      end
      otsp_pkg::ENG_FIRE_WR: begin
        if (out_free) begin
          state_d = fire_last ? otsp_pkg::ENG_IDLE : otsp_pkg::ENG_FIRE_RD;
        end
      end
      otsp_pkg::ENG_RESP: begin
        if (out_free) begin
          state_d = otsp_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_d = otsp_pkg::ENG_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_d       = cmd_q;
    status_d    = status_q;
    idx_d       = idx_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    fire_n_d    = fire_n_q;
    fire_list_d = fire_list_q;
    fire_k_d    = fire_k_q;
    pend_out_d  = pend_out_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = match_idx_q;
    rd_addr     = idx_q;

    // Evaluate the slot whose read data arrived this cycle.
    if (chk_vld_q) begin
      if (hit_valid && key_eq && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = chk_idx_q;
      end
      if (!hit_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
      if (cmd_q.op == otsp_pkg::OP_TICK && hit_valid && !age[31] &&
          fire_n_q < FireCW'(otsp_pkg::RES_MAX)) begin
        fire_list_d[fire_n_q[FireW-1:0]] = chk_idx_q;
        fire_n_d = fire_n_q + 1'b1;
      end
    end

    unique case (state_q)
      otsp_pkg::ENG_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          cmd_d     = q_data_i;
          idx_d     = '0;
          chk_vld_d = 1'b0;
          match_d   = 1'b0;
          free_d    = 1'b0;
          fire_n_d  = '0;
          fire_k_d  = '0;
          status_d  = otsp_pkg::STATUS_OK;
          if (q_data_i.op == otsp_pkg::OP_INIT) begin
            valid_d = '0;
            cnt_d   = '0;
          end else if (q_data_i.op == otsp_pkg::OP_REPLY) begin
            status_d = q_data_i.status;
          end
        end
      end
      otsp_pkg::ENG_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = idx_q;
        idx_d     = idx_q + 1'b1;
      end
      otsp_pkg::ENG_FLUSH: begin
        chk_vld_d = 1'b0;
        case (cmd_q.op)
          otsp_pkg::OP_ARM: begin
            if (match_d) begin
              wr_en    = 1'b1;
              wr_addr  = match_idx_d;
              status_d = otsp_pkg::STATUS_OK;
            end else if (free_d) begin
              wr_en             = 1'b1;
              wr_addr           = free_idx_d;
              valid_d[free_idx_d] = 1'b1;
              cnt_d             = cnt_q + 1'b1;
              status_d          = otsp_pkg::STATUS_OK;
            end else begin
              status_d = otsp_pkg::STATUS_FULL;
            end
          end
          otsp_pkg::OP_CANCEL: begin
            if (match_d) begin
              valid_d[match_idx_d] = 1'b0;
              cnt_d    = cnt_q - 1'b1;
              status_d = otsp_pkg::STATUS_OK;
            end else begin
              status_d = otsp_pkg::STATUS_NOT_FOUND;
            end
          end
          default: begin
            status_d   = otsp_pkg::STATUS_OK;
            pend_out_d = cnt_q - CntW'(fire_n_d);
          end
        endcase
      end
      otsp_pkg::ENG_FIRE_RD: begin
        rd_addr = fire_list_q[fire_k_q];
      end
      otsp_pkg::ENG_FIRE_WR: begin
        rd_addr = fire_list_q[fire_k_q];
        if (out_free) begin
          out_vld_d            = 1'b1;
          out_d.status         = otsp_pkg::STATUS_OK;
          out_d.fired          = 1'b1;
          out_d.fired_callback = rd_cb_q;
          out_d.fired_context  = rd_ctx_q;
          out_d.last           = fire_last;
          out_d.pending_count  = otsp_pkg::sat_pend(pend_out_q);
          valid_d[fire_list_q[fire_k_q]] = 1'b0;
          cnt_d                = cnt_q - 1'b1;
          fire_k_d             = fire_k_q + 1'b1;
        end
      end
      otsp_pkg::ENG_RESP: begin
        if (out_free) begin
          out_vld_d            = 1'b1;
          out_d.status         = status_q;
          out_d.fired          = 1'b0;
          out_d.fired_callback = '0;
          out_d.fired_context  = '0;
          out_d.last           = 1'b1;
          out_d.pending_count  = otsp_pkg::sat_pend(cnt_q);
        end
      end
      default: begin
        out_vld_d = out_vld_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= otsp_pkg::ENG_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    status_q    <= status_d;
    idx_q       <= idx_d;
    chk_idx_q   <= chk_idx_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    fire_n_q    <= fire_n_d;
    fire_list_q <= fire_list_d;
    fire_k_q    <= fire_k_d;
    pend_out_q  <= pend_out_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cb_mem[wr_addr]  <= cmd_q.callback;
      ctx_mem[wr_addr] <= cmd_q.context_word;
      dl_mem[wr_addr]  <= cmd_q.time_ms;
    end
    rd_cb_q  <= cb_mem[rd_addr];
    rd_ctx_q <= ctx_mem[rd_addr];
    rd_dl_q  <= dl_mem[rd_addr];
  end

  `OTSP_ASSERT(a_cnt_tracks_valid, cnt_q == CntW'($countones(valid_q)), "pending count out of step with armed slots")
  `OTSP_ASSERT_IMPLY(a_fired_key_nonzero, out_vld_q && out_q.fired, out_q.fired_callback != 32'd0, "fired result carries a free key")
  `OTSP_ASSERT_IMPLY(a_nonlast_is_fire, out_vld_q && !out_q.last, out_q.fired, "only fired results may precede the last one")
  `OTSP_ASSERT_IMPLY(a_fire_slot_armed, state_q == otsp_pkg::ENG_FIRE_WR, valid_q[fire_list_q[fire_k_q]], "firing a slot that is not armed")

endmodule

>>> hdl/one_shot_timer_slot_pool.sv
// Top level of the one-shot timer slot pool.
//
// Input channel in_valid_i/in_stall_o carries one command per transaction:
// init pool, arm timer, cancel timer or time tick. Output channel
// out_valid_o/out_stall_i carries result transactions; init, arm and cancel
// give one result, a tick gives one per expired slot (in ascending slot
// order) or a single result when nothing expires. The last result of each
// command has last set, and every result reports the pending count after
// the whole command.
// Commands pass through a two-entry queue to the slot engine, which scans
// the slot store one slot per cycle through its single read port. An arm,
// a cancel or a tick is popped while the engine is idle, all slots are
// scanned, and a flush step applies the command. A tick that fires then
// reads each expired slot in turn and gives a result for it; the rest give
// one result. Init and rejected commands skip the scan and go straight to
// the result step. The engine pops the next command only after the last
// result of the current one has been issued.
// Reset empties the queue, frees all slots and clears the ready flag at once.
// While the receiver stalls, the held result stays put and the engine waits;
// the queue keeps taking commands until it fills, then in_stall_o rises.
`timescale 1ns / 1ps

module one_shot_timer_slot_pool (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otsp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otsp_pkg::out_item_t out_data_o
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  otsp_pkg::cmd_t q_push_data;
  otsp_pkg::cmd_t q_pop_data;

  otsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  otsp_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  otsp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
